// File: src/mbsd_pkg.sv
// mbsd_pkg: shared types, constants and length lookups for the midi byte stream decoder
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package mbsd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DATA_W    = 7;
  localparam int unsigned CHAN_W    = 4;
  localparam int unsigned HELD_W    = 2;
  localparam int unsigned OUT_TDATA_W = 32;

  localparam logic [BYTE_W-1:0] STATUS_MASK = 8'h80;
  localparam logic [BYTE_W-1:0] SYSTEM_BASE = 8'hF0;
  localparam logic [BYTE_W-1:0] TYPE_MASK   = 8'hF0;
  localparam logic [BYTE_W-1:0] CHAN_MASK   = 8'h0F;

  localparam logic [HELD_W-1:0] HELD_NONE   = 2'd0;
  localparam logic [HELD_W-1:0] HELD_STATUS = 2'd1;
  localparam logic [HELD_W-1:0] HELD_ONE    = 2'd2;

  typedef struct packed {
    logic [DATA_W-1:0] second_data;
    logic [DATA_W-1:0] first_data;
    logic [CHAN_W-1:0] channel;
    logic [BYTE_W-1:0] message_type;
  } result_t;

  // message length in bytes for a status byte, zero for data bytes
  function automatic logic [HELD_W-1:0] length_of(input logic [BYTE_W-1:0] status);
    logic [HELD_W-1:0] len;
    len = 2'd0;
    if (status >= SYSTEM_BASE) begin
      case (status[3:0])
        4'h1, 4'h3: len = 2'd2;
        4'h2:       len = 2'd3;
        default:    len = 2'd1;
      endcase
    end else if (status[7]) begin
      case (status[6:4])
        3'd4, 3'd5: len = 2'd2;
        default:    len = 2'd3;
      endcase
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// File: src/mbsd_decode.sv
// mbsd_decode: message assembly state and completion decode, one byte per cycle
// depends on mbsd_pkg
`timescale 1ns / 1ps
`default_nettype none
module mbsd_decode
  import mbsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire logic [BYTE_W-1:0] item_byte,
  output logic                   result_valid,
  output result_t                result
);

  logic [HELD_W-1:0] bytes_held, bytes_held_next;
  logic [BYTE_W-1:0] last_status, last_status_next;
  logic [BYTE_W-1:0] status_byte, status_byte_next;
  logic [DATA_W-1:0] data1, data1_next;
  logic [DATA_W-1:0] data2, data2_next;
  logic              ignored;
  logic              complete;

  always_comb begin
    bytes_held_next  = bytes_held;
    last_status_next = last_status;
    status_byte_next = status_byte;
    data1_next       = data1;
    data2_next       = data2;
    ignored          = 1'b0;
    if ((item_byte & STATUS_MASK) != '0) begin
      last_status_next = item_byte;
      status_byte_next = item_byte;
      bytes_held_next  = HELD_STATUS;
    end else if (bytes_held == HELD_STATUS) begin
      data1_next      = item_byte[DATA_W-1:0];
      bytes_held_next = HELD_ONE;
    end else if (bytes_held == HELD_ONE) begin
      data2_next      = item_byte[DATA_W-1:0];
      bytes_held_next = bytes_held + HELD_STATUS;
    end else if (last_status == '0) begin
      ignored = 1'b1;
    end else begin
      // running status
      status_byte_next = last_status;
      data1_next       = item_byte[DATA_W-1:0];
      bytes_held_next  = HELD_ONE;
    end
    complete = !ignored && status_byte_next[7] &&
               (bytes_held_next >= length_of(status_byte_next));
    if (complete) begin
      bytes_held_next = HELD_NONE;
    end
    result_valid = item_valid && complete;
    if (status_byte_next >= SYSTEM_BASE) begin
      result.message_type = status_byte_next;
      result.channel      = '0;
    end else begin
      result.message_type = status_byte_next & TYPE_MASK;
      result.channel      = status_byte_next[CHAN_W-1:0] & CHAN_MASK[CHAN_W-1:0];
    end
    result.first_data  = data1_next;
    result.second_data = data2_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_held  <= HELD_NONE;
      last_status <= '0;
      status_byte <= '0;
      data1       <= '0;
      data2       <= '0;
    end else if (item_valid) begin
      bytes_held  <= bytes_held_next;
      last_status <= last_status_next;
      status_byte <= status_byte_next;
      data1       <= data1_next;
      data2       <= data2_next;
    end
  end

endmodule
`default_nettype wire

// File: src/midi_byte_stream_decoder_core.sv
// midi_byte_stream_decoder_core: top level, input register, decode and result register
// depends on mbsd_pkg and mbsd_decode
// usage:
//   slave side takes one midi byte per request on s_tdata[7:0]; bit 7 marks a status byte
//   master side gives one decoded message per request when a message completes;
//   data bytes extend the message in progress, and a data byte with no message in
//   progress reuses the last status; data bytes before any status give nothing
//   path: a completing byte reaches the master side via the input and result registers
//   throughput: one byte per cycle while m_tready does not hold a result, set by the
//   single decode stage between the input register and the result register
//   stall: while a result waits on m_tready the input register still fills; once
//   both are full s_tready drops until the result is taken
//   reset: synchronous rst clears the valid flags of both registers, the byte count,
//   the last status and the stored message bytes
`timescale 1ns / 1ps
`default_nettype none
module midi_byte_stream_decoder_core
  import mbsd_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [BYTE_W-1:0]      s_tdata,  // rx_byte
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  // message_type[7:0], channel[11:8], first_data[18:12], second_data[25:19], zero[31:26]
  output logic [OUT_TDATA_W-1:0]      m_tdata
);

  logic              in_valid;
  logic [BYTE_W-1:0] in_byte;
  logic              out_free;
  logic              advance;
  logic              res_valid;
  result_t           res;
  result_t           out_res;

  assign out_free = !m_tvalid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  mbsd_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (advance),
    .item_byte    (in_byte),
    .result_valid (res_valid),
    .result       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tdata = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_res};

endmodule
`default_nettype wire
